FILE: design/slsp_pkg.sv
package slsp_pkg;

    typedef enum logic [1:0] {
        FUNC_READ     = 2'd0,
        FUNC_WRITE    = 2'd1,
        FUNC_TICK     = 2'd2,
        FUNC_SET_LINK = 2'd3
    } func_t;

    localparam logic [15:0] ADDR_DATA      = 16'hFF01;
    localparam logic [15:0] ADDR_CONTROL   = 16'hFF02;
    localparam logic [7:0]  CONTROL_MASK   = 8'h83;
    localparam int          CONTROL_START  = 7;
    localparam logic [7:0]  UNMAPPED_READ  = 8'hFF;
    localparam logic [15:0] DEFAULT_PERIOD = 16'd512;
    localparam logic [16:0] ACCUM_MAX      = 17'h1FFFF;

    localparam int IN_TDATA_W  = 40;
    localparam int OUT_TDATA_W = 16;

    typedef struct packed {
        logic        incoming_bit;
        logic [7:0]  tick_count;
        logic [7:0]  write_data;
        logic [15:0] address;
        func_t       func;
    } item_t;

    typedef struct packed {
        logic       byte_done;
        logic [7:0] read_data;
    } result_t;

endpackage

FILE: design/slsp_core.sv
module slsp_core (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                step,
    input  slsp_pkg::item_t     item,
    input  logic [15:0]         bit_period,
    output slsp_pkg::result_t   result
);

    logic [7:0]  data_shift_reg, data_shift_next;
    logic [7:0]  control_bits_reg, control_bits_next;
    logic        running_reg, running_next;
    logic [2:0]  bits_shifted_reg, bits_shifted_next;
    logic [16:0] clock_accum_reg, clock_accum_next;
    logic        link_bit_reg, link_bit_next;

    logic [17:0] accum_sum;
    logic [16:0] accum_sat;
    logic [7:0]  control_new;
    logic        was_on;
    logic        now_on;

    assign accum_sum   = {1'b0, clock_accum_reg} + {10'd0, item.tick_count};
    assign accum_sat   = accum_sum[17] ? slsp_pkg::ACCUM_MAX : accum_sum[16:0];
    assign control_new = item.write_data & slsp_pkg::CONTROL_MASK;
    assign was_on      = control_bits_reg[slsp_pkg::CONTROL_START];
    assign now_on      = control_new[slsp_pkg::CONTROL_START];

    always_comb begin
        data_shift_next   = data_shift_reg;
        control_bits_next = control_bits_reg;
        running_next      = running_reg;
        bits_shifted_next = bits_shifted_reg;
        clock_accum_next  = clock_accum_reg;
        link_bit_next     = link_bit_reg;
        result            = '0;

        unique case (item.func)
            slsp_pkg::FUNC_READ: begin
                if (item.address == slsp_pkg::ADDR_DATA) begin
                    result.read_data = data_shift_reg;
                end else if (item.address == slsp_pkg::ADDR_CONTROL) begin
                    result.read_data = control_bits_reg;
                end else begin
                    result.read_data = slsp_pkg::UNMAPPED_READ;
                end
            end
            slsp_pkg::FUNC_WRITE: begin
                if (item.address == slsp_pkg::ADDR_DATA) begin
                    data_shift_next = item.write_data;
                end else if (item.address == slsp_pkg::ADDR_CONTROL) begin
                    control_bits_next = control_new;
                    if (!was_on && now_on) begin
                        running_next     = 1'b1;
                        clock_accum_next = '0;
                    end else if (was_on && !now_on) begin
                        running_next  = 1'b0;
                        link_bit_next = 1'b1;
                    end
                end
            end
            slsp_pkg::FUNC_TICK: begin
                if (running_reg) begin
                    clock_accum_next = accum_sat;
                    // At most one bit leaves per tick; any surplus stays accumulated.
                    if (accum_sat >= {1'b0, bit_period}) begin
                        clock_accum_next  = accum_sat - {1'b0, bit_period};
                        data_shift_next   = {data_shift_reg[6:0], link_bit_reg};
                        bits_shifted_next = bits_shifted_reg + 3'd1;
                        result.byte_done  = (bits_shifted_reg == 3'd7);
                    end
                end
            end
            slsp_pkg::FUNC_SET_LINK: begin
                link_bit_next = item.incoming_bit;
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            data_shift_reg   <= '0;
            control_bits_reg <= '0;
            running_reg      <= 1'b0;
            bits_shifted_reg <= '0;
            clock_accum_reg  <= '0;
            link_bit_reg     <= 1'b1;
        end else if (step) begin
            data_shift_reg   <= data_shift_next;
            control_bits_reg <= control_bits_next;
            running_reg      <= running_next;
            bits_shifted_reg <= bits_shifted_next;
            clock_accum_reg  <= clock_accum_next;
            link_bit_reg     <= link_bit_next;
        end
    end

endmodule

FILE: design/serial_link_shift_port_unit.sv
// Serial link port with a data byte at 0xFF01 and a control byte at 0xFF02.
// Input stream: s_axis_tuser carries the item kind (read, write, tick, set
// link bit); s_axis_tdata carries address, write data, tick count and the
// incoming link bit. Every accepted transaction yields exactly one result
// transaction on the master side: the read data (zero unless a read) and the
// byte-done flag, which is the serial interrupt request.
// The bit period is loaded through the cfg_valid/cfg_ready channel, which is
// always ready; it should only be written while no transaction is in flight.
// An accepted transaction waits in the input register, which feeds the port
// logic; the port logic loads the result register when it is empty or its
// result is being taken. Throughput is one transaction per cycle with the
// receiver ready; the port logic is a single add, compare and shift per item.
// When the receiver stalls, the result register holds and the input register
// still takes one more transaction; back pressure reaches s_axis_tready only
// when both are full.
// Reset (aresetn low, synchronous) empties both stages, clears the data and
// control bytes and the accumulator, sets the link bit to one and reloads the
// bit period with 512.
module serial_link_shift_port_unit (
    input  logic        aclk,
    input  logic        aresetn,

    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // [15:0] address, [23:16] write_data, [31:24] tick_count,
    // [32] incoming_bit, [39:33] zero
    input  logic [slsp_pkg::IN_TDATA_W-1:0] s_axis_tdata,
    // [1:0] func
    input  logic [1:0]  s_axis_tuser,

    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // [7:0] read_data, [8] byte_done, [15:9] zero
    output logic [slsp_pkg::OUT_TDATA_W-1:0] m_axis_tdata,

    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [15:0] cfg_data
);

    logic                in_valid_reg;
    slsp_pkg::item_t     in_item_reg;
    logic                out_valid_reg;
    slsp_pkg::result_t   out_result_reg;
    logic [15:0]         bit_period_reg;

    logic                advance;
    logic                s_accept;
    slsp_pkg::item_t     s_item;
    slsp_pkg::result_t   result;

    assign advance       = in_valid_reg && (!out_valid_reg || m_axis_tready);
    assign s_axis_tready = !in_valid_reg || advance;
    assign s_accept      = s_axis_tvalid && s_axis_tready;
    assign cfg_ready     = 1'b1;

    assign s_item.func         = slsp_pkg::func_t'(s_axis_tuser);
    assign s_item.address      = s_axis_tdata[15:0];
    assign s_item.write_data   = s_axis_tdata[23:16];
    assign s_item.tick_count   = s_axis_tdata[31:24];
    assign s_item.incoming_bit = s_axis_tdata[32];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_accept) begin
            in_valid_reg <= 1'b1;
        end else if (advance) begin
            in_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_accept) begin
            in_item_reg <= s_item;
        end
    end

    slsp_core u_core (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .step       (advance),
        .item       (in_item_reg),
        .bit_period (bit_period_reg),
        .result     (result)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (advance) begin
            out_valid_reg <= 1'b1;
        end else if (m_axis_tready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            out_result_reg <= result;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            bit_period_reg <= slsp_pkg::DEFAULT_PERIOD;
        end else if (cfg_valid && cfg_ready) begin
            bit_period_reg <= cfg_data;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {7'd0, out_result_reg.byte_done, out_result_reg.read_data};

endmodule

FILE: design/slsp_checker.sv
module slsp_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        s_axis_tvalid,
    input logic        s_axis_tready,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [15:0] m_axis_tdata
);

    // Nothing is presented in the cycle after reset.
    assert property (@(posedge aclk) !aresetn |=> !m_axis_tvalid)
        else $error("result valid right after reset");

    // The interrupt flag only comes from ticks, which never return read data.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid && m_axis_tdata[8] |-> m_axis_tdata[7:0] == 8'd0)
        else $error("byte done together with read data");

    // Once an acceptance has passed the input and result registers, some result must be valid.
    assert property (@(posedge aclk) disable iff (!aresetn)
        s_axis_tvalid && s_axis_tready |=> ##1 m_axis_tvalid)
        else $error("result missing two cycles after acceptance");

    // A stalled result holds its value.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("stalled result changed");

endmodule

bind serial_link_shift_port_unit slsp_checker u_slsp_checker (
    .aclk          (aclk),
    .aresetn       (aresetn),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
);
